[src/fltt_pkg.sv]
// ----------------------------------------------------------------------------
// fltt_pkg
// Types and constants shared by the flow table ring and its head unit.
// ----------------------------------------------------------------------------
package fltt_pkg;

  localparam int unsigned FlowsDefault = 64;
  localparam int unsigned KeyW         = 104;
  localparam int unsigned TsW          = 32;
  localparam int unsigned CntW         = 32;
  localparam int unsigned TimeoutW     = 16;
  localparam int unsigned LimitW       = 7;
  localparam int unsigned InDataW      = 136;
  localparam int unsigned OutDataW     = 184;
  localparam int unsigned OutSlotW     = 6;
  localparam int unsigned OutSatW      = 7;

  localparam logic       OP_PACKET = 1'b0;
  localparam logic       OP_SWEEP  = 1'b1;
  localparam logic [0:0] REG_TIMEOUT = 1'b0;
  localparam logic [0:0] REG_LIMIT   = 1'b1;

  localparam logic [CntW-1:0] CntMax = '1;

  // key: {src_ip, dst_ip, sport, dport, protocol}
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [TsW-1:0]  seen;
    logic [CntW-1:0] pkts;
  } entry_t;

  typedef enum logic [3:0] {
    PASS_LOOK  = 4'b0001,
    PASS_FIND  = 4'b0010,
    PASS_INS   = 4'b0100,
    PASS_SWEEP = 4'b1000
  } pass_e;

  typedef struct packed {
    pass_e mode;
    logic  kill;       // entry at head is the victim of the previous pass
    logic  ins_done;
    logic  best_valid;
  } head_ctl_t;

  typedef struct packed {
    logic match;
    logic killed;
    logic cand;
    logic ins;
    logic expire;
  } head_flags_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + CntW'(1);
  endfunction

endpackage

[src/fltt_cell.sv]
// ----------------------------------------------------------------------------
// fltt_cell
// One table entry of the ring; takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module fltt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  fltt_pkg::entry_t entry_i,
  output fltt_pkg::entry_t entry_o
);
  import fltt_pkg::*;

  logic            valid_q;
  logic [KeyW-1:0] key_q;
  logic [TsW-1:0]  seen_q;
  logic [CntW-1:0] pkts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q  <= entry_i.key;
      seen_q <= entry_i.seen;
      pkts_q <= entry_i.pkts;
    end
  end

  assign entry_o = '{valid: valid_q, key: key_q, seen: seen_q, pkts: pkts_q};

endmodule

[src/fltt_head.sv]
// ----------------------------------------------------------------------------
// fltt_head
// Update logic applied to the entry leaving the ring's head.
// ----------------------------------------------------------------------------
module fltt_head (
  input  fltt_pkg::head_ctl_t            ctl_i,
  input  fltt_pkg::entry_t               entry_i,
  input  logic [fltt_pkg::KeyW-1:0]      key_i,
  input  logic [fltt_pkg::TsW-1:0]       now_i,
  input  logic [fltt_pkg::TimeoutW-1:0]  timeout_i,
  input  logic [fltt_pkg::TsW-1:0]       best_ts_i,
  output fltt_pkg::entry_t               entry_o,
  output fltt_pkg::head_flags_t          flags_o
);
  import fltt_pkg::*;

  entry_t         e;
  logic [TsW-1:0] age;

  always_comb begin
    e       = entry_i;
    flags_o = '0;
    age     = now_i - entry_i.seen;
    if (ctl_i.kill && e.valid) begin
      e.valid        = 1'b0;
      flags_o.killed = 1'b1;
    end
    case (ctl_i.mode)
      PASS_LOOK: begin
        if (e.valid && e.key == key_i) begin
          flags_o.match = 1'b1;
          e.seen        = now_i;
          e.pkts        = sat_inc(e.pkts);
        end
      end
      PASS_FIND: begin
        flags_o.cand = e.valid && (!ctl_i.best_valid || e.seen < best_ts_i);
      end
      PASS_INS: begin
        if (!e.valid && !ctl_i.ins_done) begin
          flags_o.ins = 1'b1;
          e.valid     = 1'b1;
          e.key       = key_i;
          e.seen      = now_i;
          e.pkts      = '0;
        end
      end
      PASS_SWEEP: begin
        // negative age never expires
        if (e.valid && !age[TsW-1] && age > TsW'(timeout_i)) begin
          flags_o.expire = 1'b1;
          e.valid        = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign entry_o = e;

endmodule

[src/flow_table_lru_timeout.sv]
// ----------------------------------------------------------------------------
// flow_table_lru_timeout
// Fully associative five-tuple flow table with oldest-first eviction.
// ----------------------------------------------------------------------------
// The table is a ring of FLOWS entry registers that rotates one place per
// cycle while a pass runs, past a single update unit, so every pass over the
// table leaves the entries in their home slots. A sweep is one pass, a hit
// one lookup pass, a miss that fits a lookup and an insert pass, and a miss
// at the limit one lookup pass, one pass for each of k = max(1, occupancy/10)
// evicted entries to find the oldest, and an insert pass that also removes the
// last victim. One request is worked on at a time; the next is taken while the
// result waits on the output.
module flow_table_lru_timeout #(
  parameter int unsigned FLOWS = fltt_pkg::FlowsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // protocol[7:0], src_ip[39:8], sport[55:40], dst_ip[87:56],
  // dport[103:88], now_seconds[135:104]
  input  logic [fltt_pkg::InDataW-1:0]    s_axis_tdata_i,
  // operation[0]
  input  logic                            s_axis_tuser_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // hit[0], slot[6:1], pkt_count[38:7], evicted_count[45:39],
  // flow_count[52:46], hits_total[84:53], misses_total[116:85],
  // timeout_evictions_total[148:117], lru_evictions_total[180:149], zero pad
  output logic [fltt_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [0:0]                      cfg_index_i,
  input  logic [fltt_pkg::TimeoutW-1:0]   cfg_data_i
);
  import fltt_pkg::*;

  localparam int unsigned SlotW = $clog2(FLOWS);
  localparam int unsigned OccW  = $clog2(FLOWS + 1);
  localparam int unsigned CmpW  = (OccW > LimitW) ? OccW : LimitW;
  localparam int unsigned Shr   = OccW + 3;
  localparam int unsigned KMul  = (1 << Shr) / 10 + 1;
  localparam int unsigned ProdW = OccW + Shr;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOOK  = 7'b0000010,
    ST_KSET  = 7'b0000100,
    ST_FIND  = 7'b0001000,
    ST_INS   = 7'b0010000,
    ST_SWEEP = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [TimeoutW-1:0] timeout_q;
  logic [LimitW-1:0]   limit_q;

  logic [KeyW-1:0]  key_q;
  logic [TsW-1:0]   now_q;
  logic [SlotW-1:0] cnt_q, cnt_d;
  logic             found_q, found_d;
  logic             ins_done_q, ins_done_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [CntW-1:0]  pkts_q, pkts_d;
  logic [OccW-1:0]  occ_q, occ_d;
  logic [OccW-1:0]  removed_q, removed_d;
  logic [OccW-1:0]  k_q, k_d;
  logic [OccW-1:0]  nfind_q, nfind_d;
  logic             best_valid_q, best_valid_d;
  logic [TsW-1:0]   best_ts_q, best_ts_d;
  logic [SlotW-1:0] best_slot_q, best_slot_d;
  logic             kill_en_q, kill_en_d;
  logic [SlotW-1:0] kill_slot_q, kill_slot_d;
  logic [CntW-1:0]  hits_q, hits_d, miss_q, miss_d, tmo_q, tmo_d, lru_q, lru_d;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  entry_t      ring_q [FLOWS];
  entry_t      head_out;
  head_ctl_t   ctl;
  head_flags_t flags;
  logic        shift;
  logic        pass_end;
  logic        in_acc;
  logic        out_load;

  logic [CmpW-1:0]  lim;
  logic [ProdW-1:0] prod;
  logic [OccW-1:0]  kq;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // ring of entries
  assign shift = (state_q == ST_LOOK) || (state_q == ST_FIND) ||
                 (state_q == ST_INS)  || (state_q == ST_SWEEP);

  for (genvar i = 0; i < FLOWS; i++) begin : g_ring
    entry_t nxt;
    if (i == FLOWS - 1) begin : g_tail
      assign nxt = head_out;
    end else begin : g_mid
      assign nxt = ring_q[i+1];
    end
    fltt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (nxt),
      .entry_o (ring_q[i])
    );
  end

  always_comb begin
    case (state_q)
      ST_FIND:  ctl.mode = PASS_FIND;
      ST_INS:   ctl.mode = PASS_INS;
      ST_SWEEP: ctl.mode = PASS_SWEEP;
      default:  ctl.mode = PASS_LOOK;
    endcase
    ctl.kill       = kill_en_q && (cnt_q == kill_slot_q) &&
                     ((state_q == ST_FIND) || (state_q == ST_INS));
    ctl.ins_done   = ins_done_q;
    ctl.best_valid = best_valid_q;
  end

  fltt_head u_head (
    .ctl_i     (ctl),
    .entry_i   (ring_q[0]),
    .key_i     (key_q),
    .now_i     (now_q),
    .timeout_i (timeout_q),
    .best_ts_i (best_ts_q),
    .entry_o   (head_out),
    .flags_o   (flags)
  );

  assign pass_end = (cnt_q == SlotW'(FLOWS - 1));

  always_comb begin
    if (limit_q == '0 || CmpW'(limit_q) > CmpW'(FLOWS)) lim = CmpW'(FLOWS);
    else                                                  lim = CmpW'(limit_q);
    prod = ProdW'(occ_q) * ProdW'(KMul);
    kq   = prod[ProdW-1:Shr];
  end

  function automatic logic [OutSatW-1:0] sat7(input logic [OccW-1:0] v);
    logic [CmpW-1:0] w;
    w    = CmpW'(v);
    sat7 = (w > CmpW'(127)) ? OutSatW'(127) : w[OutSatW-1:0];
  endfunction

  logic [SlotW+OutSlotW-1:0] slot_ext;
  assign slot_ext = (SlotW + OutSlotW)'(slot_q);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d      = state_q;
    cnt_d        = shift ? (pass_end ? '0 : cnt_q + SlotW'(1)) : cnt_q;
    found_d      = found_q;
    ins_done_d   = ins_done_q;
    slot_d       = slot_q;
    pkts_d       = pkts_q;
    occ_d        = occ_q;
    removed_d    = removed_q;
    k_d          = k_q;
    nfind_d      = nfind_q;
    best_valid_d = best_valid_q;
    best_ts_d    = best_ts_q;
    best_slot_d  = best_slot_q;
    kill_en_d    = kill_en_q;
    kill_slot_d  = kill_slot_q;
    hits_d       = hits_q;
    miss_d       = miss_q;
    tmo_d        = tmo_q;
    lru_d        = lru_q;

    if (flags.killed) begin
      removed_d = removed_d + OccW'(1);
      lru_d     = sat_inc(lru_d);
    end
    if (flags.expire) begin
      removed_d = removed_d + OccW'(1);
      tmo_d     = sat_inc(tmo_d);
    end
    occ_d = occ_q - OccW'(flags.killed) - OccW'(flags.expire) + OccW'(flags.ins);
    // head compares keys in every idle state too; only the lookup pass counts
    if (flags.match && (state_q == ST_LOOK)) begin
      found_d = 1'b1;
      slot_d  = cnt_q;
      pkts_d  = head_out.pkts;
    end
    if (flags.ins) begin
      ins_done_d = 1'b1;
      slot_d     = cnt_q;
    end
    if (flags.cand) begin
      best_valid_d = 1'b1;
      best_ts_d    = ring_q[0].seen;
      best_slot_d  = cnt_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d        = '0;
          found_d      = 1'b0;
          ins_done_d   = 1'b0;
          slot_d       = '0;
          pkts_d       = '0;
          removed_d    = '0;
          best_valid_d = 1'b0;
          kill_en_d    = 1'b0;
          state_d      = (s_axis_tuser_i == OP_SWEEP) ? ST_SWEEP : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (pass_end) begin
          if (found_d) begin
            hits_d  = sat_inc(hits_q);
            state_d = ST_DONE;
          end else begin
            miss_d  = sat_inc(miss_q);
            state_d = (CmpW'(occ_q) >= lim) ? ST_KSET : ST_INS;
          end
        end
      end
      ST_KSET: begin
        k_d     = (kq == '0) ? OccW'(1) : kq;
        nfind_d = '0;
        state_d = ST_FIND;
      end
      ST_FIND: begin
        if (pass_end) begin
          // victim is removed as it passes the head on the next pass
          kill_en_d    = 1'b1;
          kill_slot_d  = best_slot_d;
          best_valid_d = 1'b0;
          nfind_d      = nfind_q + OccW'(1);
          state_d      = (nfind_q + OccW'(1) == k_q) ? ST_INS : ST_FIND;
        end
      end
      ST_INS: begin
        if (pass_end) begin
          kill_en_d = 1'b0;
          state_d   = ST_DONE;
        end
      end
      ST_SWEEP: begin
        if (pass_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      timeout_q    <= TimeoutW'(60);
      limit_q      <= '0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      ins_done_q   <= 1'b0;
      occ_q        <= '0;
      removed_q    <= '0;
      k_q          <= '0;
      nfind_q      <= '0;
      best_valid_q <= 1'b0;
      kill_en_q    <= 1'b0;
      hits_q       <= '0;
      miss_q       <= '0;
      tmo_q        <= '0;
      lru_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      found_q      <= found_d;
      ins_done_q   <= ins_done_d;
      occ_q        <= occ_d;
      removed_q    <= removed_d;
      k_q          <= k_d;
      nfind_q      <= nfind_d;
      best_valid_q <= best_valid_d;
      kill_en_q    <= kill_en_d;
      hits_q       <= hits_d;
      miss_q       <= miss_d;
      tmo_q        <= tmo_d;
      lru_q        <= lru_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_TIMEOUT: timeout_q <= cfg_data_i;
          REG_LIMIT:   limit_q   <= cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
      if (out_load)             out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= {s_axis_tdata_i[39:8], s_axis_tdata_i[87:56], s_axis_tdata_i[55:40],
                s_axis_tdata_i[103:88], s_axis_tdata_i[7:0]};
      now_q <= s_axis_tdata_i[135:104];
    end
    slot_q      <= slot_d;
    pkts_q      <= pkts_d;
    best_ts_q   <= best_ts_d;
    best_slot_q <= best_slot_d;
    kill_slot_q <= kill_slot_d;
    if (out_load) begin
      out_data_q <= {3'b000, lru_q, tmo_q, miss_q, hits_q, sat7(occ_q), sat7(removed_q),
                     pkts_q, slot_ext[OutSlotW-1:0], found_q};
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(occ_q) <= CmpW'(FLOWS))
    else $error("occupancy above table size");

  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOK && found_q) |-> !flags.match)
    else $error("flow key present in two slots");

  a_insert_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS && pass_end) |-> (ins_done_q || flags.ins))
    else $error("miss found no free slot");

  a_kill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.kill |-> flags.killed)
    else $error("eviction victim was not a live entry");
`endif

endmodule
